// ----- hdl/ril_pkg.sv -----
// Shared constants, codes and types for the ranged interpolation lookup.
package ril_pkg;

    // Field widths fixed by the item format
    localparam int ADDR_W     = 64;
    localparam int BASE_W     = 12;
    localparam int POS_W      = 13;
    localparam int SLOT_W     = 12;
    localparam int UNIT_W     = 6;
    localparam int FUNC_OUT_W = 32;
    localparam int MARK_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 2;
    localparam int CFG_W      = 7;

    // Default sizes
    localparam int DEF_MAX_UNITS    = 64;
    localparam int DEF_MAX_LINES    = 4096;
    localparam int DEF_FUNC_ID_BITS = 32;

    // Transaction action codes
    localparam logic [ACT_W-1:0] ACT_UNIT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LINE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    // Unit descriptor as held in the unit memory
    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
        logic [BASE_W-1:0] base;
        logic [POS_W-1:0]  total;
    } t_unit;

endpackage

// ----- hdl/ril_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module ril_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ranged_interpolation_lookup_top.sv -----
// A lookup may check the recent unit, binary-search the units, open a nonempty unit and
// fetch its end entries, then read a direct hit or run interpolation probes, each of which
// takes its quotient from the bit-serial quotient unit.
// One transaction at a time; the single read port of each memory sets the pace.
// Synchronous active-low reset clears the sequencer, unit count, recent unit and output
// valid flag; both memories hold garbage until written and get no clearing pass.
module ranged_interpolation_lookup_top #(
    parameter int MAX_UNITS    = ril_pkg::DEF_MAX_UNITS,
    parameter int MAX_LINES    = ril_pkg::DEF_MAX_LINES,
    parameter int FUNC_ID_BITS = ril_pkg::DEF_FUNC_ID_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ril_pkg::ACT_W-1:0]      i_action,
    input  logic [ril_pkg::ADDR_W-1:0]     i_key_address,
    input  logic [ril_pkg::UNIT_W-1:0]     i_unit_slot,
    input  logic [ril_pkg::ADDR_W-1:0]     i_range_start,
    input  logic [ril_pkg::ADDR_W-1:0]     i_range_end,
    input  logic [ril_pkg::BASE_W-1:0]     i_first_line,
    input  logic [ril_pkg::POS_W-1:0]      i_line_total,
    input  logic [ril_pkg::SLOT_W-1:0]     i_line_slot,
    input  logic [ril_pkg::FUNC_OUT_W-1:0] i_func_ident,
    input  logic [ril_pkg::MARK_W-1:0]     i_function_mark,
    input  logic [ril_pkg::BYTE_W-1:0]     i_original_byte,
    input  logic                           i_cfg_we,
    input  logic [ril_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [ril_pkg::FUNC_OUT_W-1:0] o_hit_func_ident,
    output logic [ril_pkg::MARK_W-1:0]     o_hit_function_mark,
    output logic [ril_pkg::BYTE_W-1:0]     o_hit_original_byte,
    output logic [ril_pkg::UNIT_W-1:0]     o_hit_unit,
    output logic [ril_pkg::SLOT_W-1:0]     o_hit_line
);
    import ril_pkg::*;

    localparam int UW     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int UNW    = $clog2(MAX_UNITS + 1);
    localparam int LW     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int FB     = FUNC_ID_BITS;
    localparam int LDW    = ADDR_W + FB + MARK_W + BYTE_W;
    localparam int UDW    = $bits(t_unit);
    localparam int CW     = $clog2(POS_W);
    localparam int MOD_SH = 30;
    localparam logic [30:0] MOD_RECIP =
        31'(((64'd1 << MOD_SH) + 64'(MAX_LINES) - 64'd1) / 64'(MAX_LINES));
    localparam logic signed [POS_W:0] POS_ONE = (POS_W+1)'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_BS, S_BS_CHK, S_UNIT, S_LA0, S_LA, S_RA,
        S_LOOP, S_MUL, S_DIV, S_IDX, S_PROBE, S_HIT, S_DONE
    } t_state;

    // Line slot of a position: (base + pos) modulo MAX_LINES via reciprocal
    function automatic logic [LW-1:0] slot_of(input logic [BASE_W-1:0] base,
                                              input logic [POS_W-1:0]  pos);
        logic [POS_W:0]    s;
        logic [POS_W+31:0] prod;
        logic [POS_W:0]    q;
        logic [31:0]       qm;
        logic [POS_W:0]    rem;
        s    = (POS_W+1)'(base) + (POS_W+1)'(pos);
        prod = (POS_W+32)'(s) * (POS_W+32)'(MOD_RECIP);
        q    = (POS_W+1)'(prod >> MOD_SH);
        qm   = 32'(q) * 32'(MAX_LINES);
        rem  = s - (POS_W+1)'(qm);
        return LW'(rem);
    endfunction

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_units;
    logic [UW-1:0]            r_recent, n_recent;
    logic [ADDR_W-1:0]        r_key, n_key;
    logic [UNW-1:0]           r_n, n_n, r_l, n_l, r_r, n_r;
    logic [UW-1:0]            r_m, n_m, r_unit, n_unit;
    logic                     r_have, n_have, r_hit, n_hit;
    logic [BASE_W-1:0]        r_base, n_base;
    logic [POS_W-1:0]         r_total, n_total;
    logic signed [POS_W:0]    r_left, n_left, r_right, n_right, r_idx, n_idx;
    logic [ADDR_W-1:0]        r_la, n_la, r_ra, n_ra, r_dk, n_dk, r_dd, n_dd;
    logic [ADDR_W-1:0]        r_rem, n_rem;
    logic [POS_W-1:0]         r_span, n_span, r_lowq, n_lowq, r_q, n_q;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [LW-1:0]            r_islot, n_islot, r_hslot, n_hslot;
    logic [FB-1:0]            r_hfunc, n_hfunc;
    logic [MARK_W-1:0]        r_hmark, n_hmark;
    logic [BYTE_W-1:0]        r_horig, n_horig;
    logic                     r_out_valid;
    logic                     r_found;
    logic [FUNC_OUT_W-1:0]    r_o_func;
    logic [MARK_W-1:0]        r_o_mark;
    logic [BYTE_W-1:0]        r_o_orig;
    logic [UNIT_W-1:0]        r_o_unit;
    logic [SLOT_W-1:0]        r_o_line;

    logic                     in_acc, load_out;
    logic                     u_we, l_we;
    logic [UW-1:0]            u_raddr;
    logic [LW-1:0]            l_raddr;
    logic [UDW-1:0]           u_rdata;
    logic [LDW-1:0]           l_rdata;
    t_unit                    u_rd, u_wd;
    logic [ADDR_W-1:0]        l_addr;
    logic [ADDR_W+POS_W-1:0]  prod;
    logic [ADDR_W:0]          div_t, div_diff;
    logic                     div_ge;
    logic [UNW:0]             bs_sum;
    logic signed [POS_W:0]    idx_dn, idx_up;

    assign in_acc = i_in_valid && o_in_ready;
    assign u_rd   = t_unit'(u_rdata);
    assign l_addr = l_rdata[LDW-1 -: ADDR_W];

    // Write side of both memories
    assign u_we = in_acc && (i_action == ACT_UNIT) &&
                  (11'(i_unit_slot) < 11'(MAX_UNITS));
    assign l_we = in_acc && (i_action == ACT_LINE) &&
                  (17'(i_line_slot) < 17'(MAX_LINES));
    assign u_wd = '{low: i_range_start, high: i_range_end,
                    base: i_first_line, total: i_line_total};

    ril_ram #(.WIDTH(UDW), .DEPTH(MAX_UNITS)) u_unit_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (UW'(i_unit_slot)),
        .i_wdata (u_wd),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    ril_ram #(.WIDTH(LDW), .DEPTH(MAX_LINES)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (LW'(i_line_slot)),
        .i_wdata ({i_key_address, FB'(i_func_ident), i_function_mark, i_original_byte}),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // Datapath pieces: interpolation product, one quotient bit a cycle
    assign prod     = (ADDR_W+POS_W)'(r_dk) * (ADDR_W+POS_W)'(r_span);
    assign div_t    = {r_rem, r_lowq[POS_W-1]};
    assign div_ge   = div_t >= {1'b0, r_dd};
    assign div_diff = div_t - {1'b0, r_dd};
    assign bs_sum   = (UNW+1)'(r_l) + (UNW+1)'(r_r);
    assign idx_dn   = r_idx - POS_ONE;
    assign idx_up   = r_idx + POS_ONE;

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Sequencer next-state logic and memory read addresses
    always_comb begin
        n_state = r_state;  n_recent = r_recent; n_key = r_key;   n_n = r_n;
        n_l = r_l;          n_r = r_r;           n_m = r_m;       n_unit = r_unit;
        n_have = r_have;    n_hit = r_hit;       n_base = r_base; n_total = r_total;
        n_left = r_left;    n_right = r_right;   n_idx = r_idx;   n_la = r_la;
        n_ra = r_ra;        n_dk = r_dk;         n_dd = r_dd;     n_rem = r_rem;
        n_span = r_span;    n_lowq = r_lowq;     n_q = r_q;       n_cnt = r_cnt;
        n_islot = r_islot;  n_hslot = r_hslot;   n_hfunc = r_hfunc;
        n_hmark = r_hmark;  n_horig = r_horig;
        u_raddr = '0;
        l_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ACT_LOOKUP) begin
                    n_key  = i_key_address;
                    n_have = 1'b0;
                    n_hit  = 1'b0;
                    n_n    = (11'(r_units) > 11'(MAX_UNITS)) ? UNW'(MAX_UNITS)
                                                             : UNW'(r_units);
                    n_l    = '0;
                    n_r    = n_n;
                    if (UNW'(r_recent) < n_n) begin
                        u_raddr = r_recent;
                        n_state = S_REC;
                    end else begin
                        n_state = S_BS;
                    end
                end
            end
            S_REC: begin
                if (u_rd.low <= r_key && r_key <= u_rd.high) begin
                    n_unit  = r_recent;
                    n_have  = 1'b1;
                    n_base  = u_rd.base;
                    n_total = u_rd.total;
                    n_state = S_UNIT;
                end else begin
                    n_state = S_BS;
                end
            end
            S_BS: begin
                if (r_r > r_l) begin
                    n_m     = UW'(bs_sum >> 1);
                    u_raddr = n_m;
                    n_state = S_BS_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BS_CHK: begin
                if (r_key < u_rd.low) begin
                    n_r     = UNW'(r_m);
                    n_state = S_BS;
                end else if (r_key > u_rd.high) begin
                    n_l     = UNW'(r_m) + 1'b1;
                    n_state = S_BS;
                end else begin
                    n_unit   = r_m;
                    n_recent = r_m;
                    n_have   = 1'b1;
                    n_base   = u_rd.base;
                    n_total  = u_rd.total;
                    n_state  = S_UNIT;
                end
            end
            S_UNIT: begin
                if (r_total == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_left  = '0;
                    n_right = $signed({1'b0, r_total}) - POS_ONE;
                    l_raddr = slot_of(r_base, '0);
                    n_state = S_LA0;
                end
            end
            S_LA0: begin
                n_la    = l_addr;
                l_raddr = slot_of(r_base, POS_W'(r_right));
                n_state = S_RA;
            end
            S_LA: begin
                n_la    = l_addr;
                n_state = S_LOOP;
            end
            S_RA: begin
                n_ra    = l_addr;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_right < r_left || r_key < r_la || r_key > r_ra) begin
                    n_state = S_DONE;
                end else if (r_left == r_right || r_la == r_ra) begin
                    if (r_key == r_la) begin
                        n_hslot = slot_of(r_base, POS_W'(r_left));
                        l_raddr = n_hslot;
                        n_state = S_HIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_dk    = r_key - r_la;
                    n_dd    = r_ra - r_la;
                    n_span  = POS_W'(r_right - r_left);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                {n_rem, n_lowq} = prod;
                n_cnt   = CW'(POS_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = div_ge ? div_diff[ADDR_W-1:0] : div_t[ADDR_W-1:0];
                n_lowq = r_lowq << 1;
                n_q    = {r_q[POS_W-2:0], div_ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_idx   = r_left + $signed({1'b0, r_q});
                n_islot = slot_of(r_base, POS_W'(n_idx));
                l_raddr = n_islot;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_key < l_addr) begin
                    n_right = idx_dn;
                    if (idx_dn >= r_left) begin
                        l_raddr = slot_of(r_base, POS_W'(idx_dn));
                        n_state = S_RA;
                    end else begin
                        n_state = S_LOOP;
                    end
                end else if (r_key > l_addr) begin
                    n_left = idx_up;
                    if (r_right >= idx_up) begin
                        l_raddr = slot_of(r_base, POS_W'(idx_up));
                        n_state = S_LA;
                    end else begin
                        n_state = S_LOOP;
                    end
                end else begin
                    n_hit   = 1'b1;
                    n_hslot = r_islot;
                    n_hfunc = l_rdata[FB+MARK_W+BYTE_W-1 -: FB];
                    n_hmark = l_rdata[MARK_W+BYTE_W-1 -: MARK_W];
                    n_horig = l_rdata[BYTE_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_HIT: begin
                n_hit   = 1'b1;
                n_hfunc = l_rdata[FB+MARK_W+BYTE_W-1 -: FB];
                n_hmark = l_rdata[MARK_W+BYTE_W-1 -: MARK_W];
                n_horig = l_rdata[BYTE_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, configuration and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_units     <= '0;
            r_recent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_recent <= n_recent;
            if (i_cfg_we) begin
                r_units <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_key <= n_key;     r_n <= n_n;         r_l <= n_l;         r_r <= n_r;
        r_m <= n_m;         r_unit <= n_unit;   r_have <= n_have;   r_hit <= n_hit;
        r_base <= n_base;   r_total <= n_total; r_left <= n_left;   r_right <= n_right;
        r_idx <= n_idx;     r_la <= n_la;       r_ra <= n_ra;       r_dk <= n_dk;
        r_dd <= n_dd;       r_rem <= n_rem;     r_span <= n_span;   r_lowq <= n_lowq;
        r_q <= n_q;         r_cnt <= n_cnt;     r_islot <= n_islot; r_hslot <= n_hslot;
        r_hfunc <= n_hfunc; r_hmark <= n_hmark; r_horig <= n_horig;
        if (load_out) begin
            r_found  <= r_hit;
            r_o_func <= r_hit ? FUNC_OUT_W'(r_hfunc) : '0;
            r_o_mark <= r_hit ? r_hmark : '0;
            r_o_orig <= r_hit ? r_horig : '0;
            r_o_unit <= r_have ? UNIT_W'(r_unit) : '0;
            r_o_line <= r_hit ? SLOT_W'(r_hslot) : '0;
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_found             = r_found;
    assign o_hit_func_ident    = r_o_func;
    assign o_hit_function_mark = r_o_mark;
    assign o_hit_original_byte = r_o_orig;
    assign o_hit_unit          = r_o_unit;
    assign o_hit_line          = r_o_line;

endmodule
